/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Assertion disabled while reset is high.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/core/svpd_pkg.sv */
`default_nettype none

package svpd_pkg;

  localparam int PWM_PERIOD_DEF = 1000;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;
  localparam int CORDIC_STEPS = 30;

  localparam logic [14:0] SUPPLY_RESET = 15'd3072;
  localparam logic [14:0] LIMIT_RESET  = 15'd1536;

  localparam logic REG_SUPPLY = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic [31:0] INDEX_MAX    = 32'd37814;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] RECIP3       = 32'd2863311531;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [31:0] SQRT3_Q30    = 32'sd1859775393;
  localparam logic signed [34:0] ONE_Q30      = 35'sd1073741824;

  localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

`default_nettype wire

/* rtl/core/space_vector_pwm_duty_top.sv */
// Space-vector PWM duty generator, centred, three phase.
// Input stream s_*: one request per cycle while s_tready is high, carrying
// voltage_q, voltage_d and the rotor angle. Output stream m_*: three compare
// values and the sector. The APB port holds the supply voltage (address 0) and
// the command voltage limit (address 4); write them only while no request is
// in flight. The datapath holds 105 register stages; a new request may be
// accepted in every cycle unless the pipeline is stalled. The depth is set by
// the square root and the divider, each a load stage and 32 bit-per-stage
// steps, the 30-step sine CORDIC with its load stage, and eight stages of
// clamping, scaling and multiplication; atan2 runs alongside the square root.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready falls; nothing is lost or repeated.
// Synchronous reset clears every valid bit and restores the registers to
// a supply of 12 V and a limit of 6 V.
`default_nettype none

`include "assert_macros.svh"

module space_vector_pwm_duty_top #(
  parameter int PWM_PERIOD = svpd_pkg::PWM_PERIOD_DEF,
  parameter int ANGLE_BITS = svpd_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // voltage_q[15:0], voltage_d[31:16], rotor_angle from bit 32, zero padded
  input  wire logic [((32+ANGLE_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // duty_a[9:0], duty_b[19:10], duty_c[29:20], sector_index[32:30]
  output logic [39:0]                               m_tdata,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam int N_SQ  = svpd_pkg::SQRT_STEPS;
  localparam int N_DIV = svpd_pkg::DIV_STEPS;
  localparam int N_COR = svpd_pkg::CORDIC_STEPS;
  localparam int DEPTH = 1 + (N_SQ + 1) + (N_DIV + 1) + 2 + (N_COR + 1) + 5;

  typedef struct packed {
    logic [63:0]        rad;
    logic [34:0]        rem;
    logic [31:0]        root;
    logic signed [48:0] x;
    logic signed [48:0] y;
    logic [31:0]        z;
    logic [15:0]        qmag;
    logic               qneg;
    logic               dzero;
    logic [31:0]        phi;
  } sq_t;

  typedef struct packed {
    logic [31:0] num;
    logic [15:0] rem;
    logic [31:0] quot;
    logic        nz;
    logic        neg;
    logic [31:0] phi;
  } dv_t;

  typedef struct packed {
    logic signed [33:0] xa;
    logic signed [33:0] ya;
    logic signed [33:0] za;
    logic signed [33:0] xb;
    logic signed [33:0] yb;
    logic signed [33:0] zb;
    logic signed [16:0] m;
    logic [2:0]         sector;
  } co_t;

  logic [14:0] supply;
  logic [14:0] limit;
  logic [DEPTH-1:0] vld;
  logic adv;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply <= svpd_pkg::SUPPLY_RESET;
      limit  <= svpd_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        svpd_pkg::REG_SUPPLY: supply <= pwdata[14:0];
        svpd_pkg::REG_LIMIT:  limit  <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      svpd_pkg::REG_SUPPLY: prdata = {17'd0, supply};
      svpd_pkg::REG_LIMIT:  prdata = {17'd0, limit};
    endcase
  end

  assign adv      = !vld[DEPTH-1] || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // Input stage: clamp the commands and widen the angle to a 32-bit turn.
  logic signed [15:0] s0_q;
  logic signed [15:0] s0_d;
  logic [31:0]        s0_phi;
  logic signed [16:0] q17, d17, lim17, q_c, d_c;

  always_comb begin
    q17   = 17'(signed'(s_tdata[15:0]));
    d17   = 17'(signed'(s_tdata[31:16]));
    lim17 = signed'({2'b00, limit});
    q_c   = (q17 > lim17) ? lim17 : ((q17 < -lim17) ? -lim17 : q17);
    d_c   = (d17 > lim17) ? lim17 : ((d17 < -lim17) ? -lim17 : d17);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_q   <= q_c[15:0];
      s0_d   <= d_c[15:0];
      s0_phi <= 32'(s_tdata[32 +: ANGLE_BITS]) << (32 - ANGLE_BITS);
    end
  end

  // Square root of (q*q + d*d) * 2^32 alongside atan2 vectoring.
  sq_t sq_pipe [N_SQ+1];
  logic signed [31:0] qw, dw32;
  logic signed [48:0] qx, dx;
  sq_t sq_init;

  always_comb begin
    qw   = 32'(s0_q);
    dw32 = 32'(s0_d);
    qx   = 49'(s0_q) <<< 30;
    dx   = 49'(s0_d) <<< 30;
    sq_init.rad   = {32'(qw * qw) + 32'(dw32 * dw32), 32'd0};
    sq_init.rem   = '0;
    sq_init.root  = '0;
    sq_init.x     = s0_d[15] ? -dx : dx;
    sq_init.y     = s0_d[15] ? -qx : qx;
    sq_init.z     = s0_d[15] ? svpd_pkg::HALF_TURN : 32'd0;
    sq_init.qmag  = s0_q[15] ? 16'(-s0_q) : s0_q;
    sq_init.qneg  = s0_q[15];
    sq_init.dzero = (s0_d == 16'sd0);
    sq_init.phi   = s0_phi;
  end

  always_ff @(posedge clk) begin
    if (adv) sq_pipe[0] <= sq_init;
  end

  for (genvar gi = 0; gi < N_SQ; gi++) begin : g_sq
    sq_t nxt;
    logic [34:0] r2, tr;
    always_comb begin
      nxt  = sq_pipe[gi];
      r2   = {sq_pipe[gi].rem[32:0], sq_pipe[gi].rad[63:62]};
      tr   = {1'b0, sq_pipe[gi].root, 2'b01};
      nxt.rad = {sq_pipe[gi].rad[61:0], 2'b00};
      if (r2 >= tr) begin
        nxt.rem  = r2 - tr;
        nxt.root = {sq_pipe[gi].root[30:0], 1'b1};
      end else begin
        nxt.rem  = r2;
        nxt.root = {sq_pipe[gi].root[30:0], 1'b0};
      end
    end
    if (gi < N_COR) begin : g_vec
      sq_t vnx;
      always_comb begin
        vnx = nxt;
        if (sq_pipe[gi].y > 0) begin
          vnx.x = sq_pipe[gi].x + (sq_pipe[gi].y >>> gi);
          vnx.y = sq_pipe[gi].y - (sq_pipe[gi].x >>> gi);
          vnx.z = sq_pipe[gi].z + svpd_pkg::ATAN_TURNS[gi];
        end else begin
          vnx.x = sq_pipe[gi].x - (sq_pipe[gi].y >>> gi);
          vnx.y = sq_pipe[gi].y + (sq_pipe[gi].x >>> gi);
          vnx.z = sq_pipe[gi].z - svpd_pkg::ATAN_TURNS[gi];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) sq_pipe[gi+1] <= vnx;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) sq_pipe[gi+1] <= nxt;
      end
    end
  end

  // Restoring division of the magnitude by the supply voltage.
  dv_t dv_pipe [N_DIV+1];
  dv_t dv_init;

  always_comb begin
    dv_init.num  = sq_pipe[N_SQ].dzero ? {sq_pipe[N_SQ].qmag, 16'd0} : sq_pipe[N_SQ].root;
    dv_init.rem  = '0;
    dv_init.quot = '0;
    dv_init.nz   = (dv_init.num != 32'd0);
    dv_init.neg  = sq_pipe[N_SQ].dzero && sq_pipe[N_SQ].qneg;
    dv_init.phi  = sq_pipe[N_SQ].phi +
                   (sq_pipe[N_SQ].dzero ? svpd_pkg::QUARTER_TURN : sq_pipe[N_SQ].z);
  end

  always_ff @(posedge clk) begin
    if (adv) dv_pipe[0] <= dv_init;
  end

  for (genvar gi = 0; gi < N_DIV; gi++) begin : g_div
    dv_t nxt;
    logic [15:0] r2;
    always_comb begin
      nxt     = dv_pipe[gi];
      r2      = {dv_pipe[gi].rem[14:0], dv_pipe[gi].num[31]};
      nxt.num = {dv_pipe[gi].num[30:0], 1'b0};
      if (r2 >= {1'b0, supply}) begin
        nxt.rem  = r2 - {1'b0, supply};
        nxt.quot = {dv_pipe[gi].quot[30:0], 1'b1};
      end else begin
        nxt.rem  = r2;
        nxt.quot = {dv_pipe[gi].quot[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dv_pipe[gi+1] <= nxt;
    end
  end

  // Index clamp, sector and position inside the sector.
  logic signed [16:0] e1_m;
  logic [2:0]         e1_sector;
  logic [31:0]        e1_u;
  logic [31:0]        mag;
  logic signed [16:0] m_n;
  logic [34:0]        phi6;

  always_comb begin
    if (!dv_pipe[N_DIV].nz) begin
      mag = 32'd0;
    end else if (dv_pipe[N_DIV].quot > svpd_pkg::INDEX_MAX) begin
      mag = svpd_pkg::INDEX_MAX;
    end else begin
      mag = dv_pipe[N_DIV].quot;
    end
    m_n  = dv_pipe[N_DIV].neg ? -signed'(mag[16:0]) : signed'(mag[16:0]);
    phi6 = {1'b0, dv_pipe[N_DIV].phi, 2'b00} + {2'b00, dv_pipe[N_DIV].phi, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_m      <= m_n;
      e1_sector <= phi6[34:32];
      e1_u      <= phi6[31:0];
    end
  end

  // Division of both sector angles by six: halve, then multiply by 1/3.
  logic signed [16:0] e2_m;
  logic [2:0]         e2_sector;
  logic [63:0]        e2_pa;
  logic [63:0]        e2_pb;
  logic [32:0]        ua_diff;

  assign ua_diff = 33'h1_0000_0000 - {1'b0, e1_u};

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_m      <= e1_m;
      e2_sector <= e1_sector;
      e2_pa     <= 64'(ua_diff[32:1]) * 64'(svpd_pkg::RECIP3);
      e2_pb     <= 64'({1'b0, e1_u[31:1]}) * 64'(svpd_pkg::RECIP3);
    end
  end

  // Two sine lanes by CORDIC rotation.
  co_t co_pipe [N_COR+1];
  co_t co_init;

  always_comb begin
    co_init.xa     = svpd_pkg::CORDIC_START;
    co_init.ya     = '0;
    co_init.za     = signed'({3'b000, e2_pa[63:33]});
    co_init.xb     = svpd_pkg::CORDIC_START;
    co_init.yb     = '0;
    co_init.zb     = signed'({3'b000, e2_pb[63:33]});
    co_init.m      = e2_m;
    co_init.sector = e2_sector;
  end

  always_ff @(posedge clk) begin
    if (adv) co_pipe[0] <= co_init;
  end

  for (genvar gi = 0; gi < N_COR; gi++) begin : g_cor
    co_t nxt;
    logic signed [33:0] at;
    always_comb begin
      nxt = co_pipe[gi];
      at  = signed'({2'b00, svpd_pkg::ATAN_TURNS[gi]});
      if (co_pipe[gi].za >= 0) begin
        nxt.xa = co_pipe[gi].xa - (co_pipe[gi].ya >>> gi);
        nxt.ya = co_pipe[gi].ya + (co_pipe[gi].xa >>> gi);
        nxt.za = co_pipe[gi].za - at;
      end else begin
        nxt.xa = co_pipe[gi].xa + (co_pipe[gi].ya >>> gi);
        nxt.ya = co_pipe[gi].ya - (co_pipe[gi].xa >>> gi);
        nxt.za = co_pipe[gi].za + at;
      end
      if (co_pipe[gi].zb >= 0) begin
        nxt.xb = co_pipe[gi].xb - (co_pipe[gi].yb >>> gi);
        nxt.yb = co_pipe[gi].yb + (co_pipe[gi].xb >>> gi);
        nxt.zb = co_pipe[gi].zb - at;
      end else begin
        nxt.xb = co_pipe[gi].xb + (co_pipe[gi].yb >>> gi);
        nxt.yb = co_pipe[gi].yb - (co_pipe[gi].xb >>> gi);
        nxt.zb = co_pipe[gi].zb + at;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) co_pipe[gi+1] <= nxt;
    end
  end

  // Sector times: sine times index, then times sqrt(3).
  logic signed [50:0] p1_a, p1_b;
  logic [2:0]         p1_sector;
  logic signed [50:0] ya51, yb51, m51;

  always_comb begin
    ya51 = 51'(co_pipe[N_COR].ya);
    yb51 = 51'(co_pipe[N_COR].yb);
    m51  = 51'(co_pipe[N_COR].m);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_a      <= ya51 * m51;
      p1_b      <= yb51 * m51;
      p1_sector <= co_pipe[N_COR].sector;
    end
  end

  logic signed [63:0] p2_a, p2_b;
  logic [2:0]         p2_sector;
  logic signed [31:0] sa, sb;
  logic signed [63:0] sa64, sb64, k64;

  always_comb begin
    sa   = 32'(p1_a >>> 16);
    sb   = 32'(p1_b >>> 16);
    sa64 = 64'(sa);
    sb64 = 64'(sb);
    k64  = 64'(svpd_pkg::SQRT3_Q30);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_a      <= sa64 * k64;
      p2_b      <= sb64 * k64;
      p2_sector <= p1_sector;
    end
  end

  // Phase times from the sector table.
  logic signed [34:0] p3_ta, p3_tb, p3_tc;
  logic [2:0]         p3_sector;
  logic signed [34:0] t1, t2, t0, h, ta_n, tb_n, tc_n;

  always_comb begin
    t1 = 35'(p2_a >>> 30);
    t2 = 35'(p2_b >>> 30);
    t0 = svpd_pkg::ONE_Q30 - t1 - t2;
    h  = t0 >>> 1;
    case (p2_sector)
      3'd0: begin ta_n = t1 + t2 + h; tb_n = t2 + h;      tc_n = h;           end
      3'd1: begin ta_n = t1 + h;      tb_n = t1 + t2 + h; tc_n = h;           end
      3'd2: begin ta_n = h;           tb_n = t1 + t2 + h; tc_n = t2 + h;      end
      3'd3: begin ta_n = h;           tb_n = t1 + h;      tc_n = t1 + t2 + h; end
      3'd4: begin ta_n = t2 + h;      tb_n = h;           tc_n = t1 + t2 + h; end
      default: begin ta_n = t1 + t2 + h; tb_n = h;        tc_n = t1 + h;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_ta     <= ta_n;
      p3_tb     <= tb_n;
      p3_tc     <= tc_n;
      p3_sector <= p2_sector;
    end
  end

  // Scale to timer counts. A time of a whole period or more saturates anyway,
  // so it is clamped to one period before the multiply.
  function automatic logic [30:0] clamp_time(input logic signed [34:0] t);
    logic [30:0] r;
    if (t <= 0) begin
      r = '0;
    end else if (t >= svpd_pkg::ONE_Q30) begin
      r = svpd_pkg::ONE_Q30[30:0];
    end else begin
      r = t[30:0];
    end
    return r;
  endfunction

  function automatic logic [9:0] to_counts(input logic [46:0] p);
    logic [16:0] c;
    c = p[46:30];
    if (c > 17'(PWM_PERIOD)) begin
      c = 17'(PWM_PERIOD);
    end
    return c[9:0];
  endfunction

  logic [46:0] p4_a, p4_b, p4_c;
  logic [2:0]  p4_sector;

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_a      <= 47'(clamp_time(p3_ta)) * 47'(PWM_PERIOD);
      p4_b      <= 47'(clamp_time(p3_tb)) * 47'(PWM_PERIOD);
      p4_c      <= 47'(clamp_time(p3_tc)) * 47'(PWM_PERIOD);
      p4_sector <= p3_sector;
    end
  end

  logic [9:0] p5_a, p5_b, p5_c;
  logic [2:0] p5_sector;

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_a      <= to_counts(p4_a);
      p5_b      <= to_counts(p4_b);
      p5_c      <= to_counts(p4_c);
      p5_sector <= p4_sector;
    end
  end

  assign m_tvalid = vld[DEPTH-1];
  assign m_tdata  = {7'd0, p5_sector, p5_c, p5_b, p5_a};

  `ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !m_tvalid, "result valid after reset")
  `ASSERT_RUN(a_accept_enters, clk, rst, s_tvalid && s_tready |=> vld[0], "request lost at entry")
  `ASSERT_RUN(a_stall_freezes, clk, rst, !s_tready |=> $stable(vld), "pipeline moved in stall")
  `ASSERT_RUN(a_sector_range, clk, rst, m_tvalid |-> m_tdata[32:30] <= 3'd5, "sector beyond five")

endmodule

`default_nettype wire

/* bench/space_vector_pwm_duty_top_tb.sv */
`timescale 1ns / 100ps

module space_vector_pwm_duty_top_tb;

  typedef struct {
    logic [9:0] duty_a;
    logic [9:0] duty_b;
    logic [9:0] duty_c;
    logic [2:0] sector_index;
  } duty_t;

  localparam int PERIOD     = 1000;
  localparam int QUIET_MAX  = 3000;
  localparam int DRAIN_WAIT = 120;
  localparam logic [2:0] ADDR_SUPPLY = {svpd_pkg::REG_SUPPLY, 2'b00};
  localparam logic [2:0] ADDR_LIMIT  = {svpd_pkg::REG_LIMIT, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [14:0] supply_reg = svpd_pkg::SUPPLY_RESET;
  logic [14:0] limit_reg  = svpd_pkg::LIMIT_RESET;
  duty_t       expected_duties[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  space_vector_pwm_duty_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] vector_turn(longint q, longint d);
    longint x, y, nx;
    logic [31:0] z;
    if (d < 0) begin
      x = -d * 64'sd1073741824; y = -q * 64'sd1073741824; z = svpd_pkg::HALF_TURN;
    end else begin
      x = d * 64'sd1073741824; y = q * 64'sd1073741824; z = '0;
    end
    for (int i = 0; i < svpd_pkg::CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + svpd_pkg::ATAN_TURNS[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - svpd_pkg::ATAN_TURNS[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint sine_q30(longint unsigned turn);
    longint x, y, z, nx;
    x = svpd_pkg::CORDIC_START;
    y = 0;
    z = longint'(turn);
    for (int i = 0; i < svpd_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i);
        z = z - longint'(svpd_pkg::ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i);
        z = z + longint'(svpd_pkg::ATAN_TURNS[i]);
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic longint sector_time(longint s, longint m);
    longint p;
    p = (s * m) >>> 16;
    return (p * longint'(svpd_pkg::SQRT3_Q30)) >>> 30;
  endfunction

  function automatic logic [9:0] to_counts(longint t);
    longint unsigned c;
    if (t <= 0) return '0;
    c = (longint'(t) * 64'd1000) >> 30;
    if (c > PERIOD) c = PERIOD;
    return c[9:0];
  endfunction

  function automatic duty_t predict_duty(logic [15:0] vq, logic [15:0] vd,
                                         logic [15:0] ang);
    longint q, d, lim, sup, m, t1, t2, t0, h, ta, tb, tc, imax;
    longint unsigned num, p6, u;
    logic [31:0] phi;
    int sector;
    duty_t r;
    q = longint'(signed'(vq));
    d = longint'(signed'(vd));
    lim = limit_reg;
    sup = supply_reg;
    imax = svpd_pkg::INDEX_MAX;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    phi = {ang, 16'h0000};
    if (d == 0) begin
      if (sup == 0) m = (q > 0) ? imax : ((q < 0) ? -imax : 0);
      else m = (q * 65536) / sup;
      phi = phi + svpd_pkg::QUARTER_TURN;
    end else begin
      num = isqrt64(longint'(q * q + d * d) << 32);
      if (sup == 0) m = imax;
      else m = longint'(num / longint'(sup));
      phi = phi + vector_turn(q, d);
    end
    if (m > imax) m = imax;
    if (m < -imax) m = -imax;
    p6 = {32'h0, phi} * 64'd6;
    sector = int'(p6 >> 32);
    u = p6 & 64'hFFFF_FFFF;
    t1 = sector_time(sine_q30(((64'h1 << 32) - u) / 6), m);
    t2 = sector_time(sine_q30(u / 6), m);
    t0 = 64'sd1073741824 - t1 - t2;
    h = t0 >>> 1;
    case (sector)
      0: begin ta = t1 + t2 + h; tb = t2 + h;      tc = h;           end
      1: begin ta = t1 + h;      tb = t1 + t2 + h; tc = h;           end
      2: begin ta = h;           tb = t1 + t2 + h; tc = t2 + h;      end
      3: begin ta = h;           tb = t1 + h;      tc = t1 + t2 + h; end
      4: begin ta = t2 + h;      tb = h;           tc = t1 + t2 + h; end
      default: begin ta = t1 + t2 + h; tb = h;     tc = t1 + h;      end
    endcase
    r.duty_a = to_counts(ta);
    r.duty_b = to_counts(tb);
    r.duty_c = to_counts(tc);
    r.sector_index = sector[2:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_command(logic [15:0] vq, logic [15:0] vd, logic [15:0] ang);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ang, vd, vq};
    do @(negedge clk); while (!s_tready);
    expected_duties.push_back(predict_duty(vq, vd, ang));
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_duties.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    wait_drained();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_SUPPLY) supply_reg = value[14:0];
    else limit_reg = value[14:0];
  endtask

  function automatic logic [15:0] random_voltage();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return (limit_reg == 0) ? 16'h0000 : 16'($urandom_range(0, 2 * limit_reg) - limit_reg);
      2: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    forever begin
      n = draw_wait();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      if (expected_duties.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        duty_t e;
        e = expected_duties.pop_front();
        if (m_tdata[9:0] != e.duty_a) report_mismatch("duty_a", m_tdata[9:0], e.duty_a);
        if (m_tdata[19:10] != e.duty_b) report_mismatch("duty_b", m_tdata[19:10], e.duty_b);
        if (m_tdata[29:20] != e.duty_c) report_mismatch("duty_c", m_tdata[29:20], e.duty_c);
        if (m_tdata[32:30] != e.sector_index)
          report_mismatch("sector_index", m_tdata[32:30], e.sector_index);
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [15:0] volts [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'hFF00};
    calm = 1'b1;
    foreach (volts[i]) foreach (volts[j]) send_command(volts[i], volts[j], 16'h0000);
    send_command(16'h0200, 16'h0000, 16'hFFFF);
    send_command(16'hFE00, 16'h0000, 16'h2AAA);
    send_command(16'h0300, 16'h0100, 16'h5555);
    send_command(16'h0100, 16'hFD00, 16'hAAAB);
    calm = 1'b0;
  endtask

  task automatic test_zero_supply();
    write_register(ADDR_SUPPLY, 32'hFFFF_8000);
    send_command(16'h0400, 16'h0000, 16'h1000);
    send_command(16'hFC00, 16'h0000, 16'h9000);
    send_command(16'h0000, 16'h0000, 16'h4000);
    send_command(16'h0100, 16'hFF80, 16'hC000);
  endtask

  task automatic test_random(logic [14:0] sup, logic [14:0] lim, int count);
    write_register(ADDR_SUPPLY, {17'h0, sup});
    write_register(ADDR_LIMIT, {$urandom_range(0, 1) != 0 ? 17'h1FFFF : 17'h0, lim});
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      calm = (i % 40) < 8;
      send_command(random_voltage(), random_voltage(), 16'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_supply();
    test_random(15'd3072, 15'd1536, 80);
    test_random(15'd1, 15'd32767, 60);
    test_random(15'd32767, 15'd0, 40);
    test_random(15'($urandom_range(1, 32767)), 15'($urandom), 80);
    test_random(15'($urandom_range(200, 4000)), 15'($urandom_range(100, 4000)), 140);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_duties.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/svpd_pkg.sv
rtl/core/space_vector_pwm_duty_top.sv
bench/space_vector_pwm_duty_top_tb.sv
